// ===== rtl/core/lfsx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsx_pkg
// Shared types and codes for the length-framed sum/xor byte deframer.
// ----------------------------------------------------------------------------
package lfsx_pkg;

    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 10;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // status codes
    localparam logic [STATUS_W-1:0] ST_BUSY      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_READY     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BUF_SMALL = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CHECK_ERR = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEAD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DATA_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRM_MASK     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RESPOND_MASK = 2'd3;

    localparam logic [BYTE_W-1:0] NO_EXC_CODE     = 8'hFF;
    localparam logic [BYTE_W-1:0] RST_FRAME_HEAD  = 8'd0;
    localparam logic [LEN_W-1:0]  RST_MAX_DATA    = 10'd249;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_head;
        logic [LEN_W-1:0]  max_data_len;
        logic [BYTE_W-1:0] prm_mask;
        logic [BYTE_W-1:0] respond_mask;
    } t_cfg;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                payload_valid;
        logic [BYTE_W-1:0]   payload_byte;
        logic [LEN_W-1:0]    payload_index;
        logic [BYTE_W-1:0]   frame_ctrl;
        logic [BYTE_W-1:0]   frame_cmd;
        logic [LEN_W-1:0]    frame_data_len;
        logic                prm_flag;
        logic                exception_flag;
        logic [BYTE_W-1:0]   exc_code;
    } t_result;

endpackage

// ===== rtl/core/lfsx_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsx_parser
// Frame state tracker: head hunt, length check, running sum/xor and the
// per-byte result.
// ----------------------------------------------------------------------------
module lfsx_parser #(
    parameter int RX_BUFFER_BYTES = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic [lfsx_pkg::BYTE_W-1:0] i_byte,
    input  lfsx_pkg::t_cfg            i_cfg,
    output lfsx_pkg::t_result         o_res
);

    localparam int CW = lfsx_pkg::COUNT_W;
    localparam int LW = lfsx_pkg::LEN_W;
    localparam int BW = lfsx_pkg::BYTE_W;

    localparam logic [CW-1:0] POS_HUNT   = CW'(0);
    localparam logic [CW-1:0] POS_LEN_LO = CW'(1);
    localparam logic [CW-1:0] POS_LEN_HI = CW'(2);
    localparam logic [CW-1:0] POS_CTRL   = CW'(3);
    localparam logic [CW-1:0] POS_CMD    = CW'(4);
    localparam logic [CW-1:0] POS_DATA   = CW'(5);
    localparam logic [CW-1:0] HDR_TAIL   = CW'(7);
    localparam logic [CW-1:0] BUF_LIM    = CW'(RX_BUFFER_BYTES);

    logic [CW-1:0] r_count, n_count;
    logic [LW-1:0] r_dlen, n_dlen;
    logic [BW-1:0] r_len_lo, n_len_lo;
    logic [BW-1:0] r_sum, n_sum;
    logic [BW-1:0] r_xor, n_xor;
    logic [BW-1:0] r_ctrl, n_ctrl;
    logic [BW-1:0] r_cmd, n_cmd;
    logic [BW-1:0] r_last, n_last;
    logic          r_sum_ok, n_sum_ok;

    logic [LW-1:0] len10;
    logic          too_long;
    logic          too_big;
    logic [CW-1:0] data_end;
    logic [CW-1:0] data_idx;
    logic          exc;

    assign len10    = {i_byte[1:0], r_len_lo};
    assign too_long = (i_byte[7:2] != '0) || (len10 > i_cfg.max_data_len);
    assign too_big  = ({1'b0, len10} + HDR_TAIL) > BUF_LIM;
    assign data_end = POS_DATA + {1'b0, r_dlen};
    assign data_idx = r_count - POS_DATA;
    assign exc      = (r_ctrl & i_cfg.respond_mask) != '0;

    always_comb begin
        n_count  = r_count;
        n_dlen   = r_dlen;
        n_len_lo = r_len_lo;
        n_sum    = r_sum;
        n_xor    = r_xor;
        n_ctrl   = r_ctrl;
        n_cmd    = r_cmd;
        n_last   = r_last;
        n_sum_ok = r_sum_ok;
        o_res    = '0;
        if (r_count == POS_HUNT) begin
            if (i_byte == i_cfg.frame_head) begin
                n_count  = POS_LEN_LO;
                n_sum    = '0;
                n_xor    = '0;
                n_sum_ok = 1'b0;
            end
        end else begin
            n_count = r_count + CW'(1);
            case (r_count)
                POS_LEN_LO: begin
                    n_len_lo = i_byte;
                    n_sum    = r_sum + i_byte;
                    n_xor    = r_xor ^ i_byte;
                end
                POS_LEN_HI: begin
                    n_sum = r_sum + i_byte;
                    n_xor = r_xor ^ i_byte;
                    if (too_long) begin
                        n_count      = POS_HUNT;
                        o_res.status = lfsx_pkg::ST_TOO_LONG;
                    end else if (too_big) begin
                        n_count      = POS_HUNT;
                        o_res.status = lfsx_pkg::ST_BUF_SMALL;
                    end else begin
                        n_dlen = len10;
                    end
                end
                POS_CTRL: begin
                    n_ctrl = i_byte;
                    n_sum  = r_sum + i_byte;
                    n_xor  = r_xor ^ i_byte;
                end
                POS_CMD: begin
                    n_cmd = i_byte;
                    n_sum = r_sum + i_byte;
                    n_xor = r_xor ^ i_byte;
                end
                default: begin
                    if (r_count < data_end) begin
                        n_sum               = r_sum + i_byte;
                        n_xor               = r_xor ^ i_byte;
                        n_last              = i_byte;
                        o_res.payload_valid = 1'b1;
                        o_res.payload_byte  = i_byte;
                        o_res.payload_index = data_idx[LW-1:0];
                    end else if (r_count == data_end) begin
                        n_sum_ok = (i_byte == r_sum);
                    end else begin
                        n_count = POS_HUNT;
                        if (r_sum_ok && (i_byte == r_xor)) begin
                            o_res.status         = lfsx_pkg::ST_READY;
                            o_res.frame_ctrl     = r_ctrl;
                            o_res.frame_cmd      = r_cmd;
                            o_res.frame_data_len = r_dlen;
                            o_res.prm_flag       = (r_ctrl & i_cfg.prm_mask) != '0;
                            o_res.exception_flag = exc;
                            o_res.exc_code       = (exc && (r_dlen != '0)) ?
                                                   r_last : lfsx_pkg::NO_EXC_CODE;
                        end else begin
                            o_res.status = lfsx_pkg::ST_CHECK_ERR;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= POS_HUNT;
        end else if (i_en) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dlen   <= n_dlen;
            r_len_lo <= n_len_lo;
            r_sum    <= n_sum;
            r_xor    <= n_xor;
            r_ctrl   <= n_ctrl;
            r_cmd    <= n_cmd;
            r_last   <= n_last;
            r_sum_ok <= n_sum_ok;
        end
    end

    a_end_hunts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && (o_res.status != lfsx_pkg::ST_BUSY)) |=> (r_count == POS_HUNT))
        else $error("frame end did not return to hunting");

    a_payload_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.payload_valid |-> (r_count >= POS_DATA))
        else $error("payload byte before data position");

    a_payload_no_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.payload_valid |-> (o_res.status == lfsx_pkg::ST_BUSY))
        else $error("payload byte carries a frame status");

endmodule

// ===== rtl/core/length_framed_sum_xor_byte_deframer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_framed_sum_xor_byte_deframer_core
// Length-prefixed frame receiver with 8-bit sum and xor check.
// ----------------------------------------------------------------------------
// Takes one received byte per transaction and returns exactly one result
// transaction per byte through a single result register. The input is ready
// whenever that register is empty or being taken, so one byte per clock
// while m_axis_tready is high. Data bytes come out as they arrive with their
// index; the length high byte can give a length error, the xor byte frame
// ready or a check error. Nothing is buffered, so the consumer drops the
// payload on error. Registers are written through the plain write port while
// the block is idle; the user must ensure this, the block does not enforce it.
module length_framed_sum_xor_byte_deframer_core #(
    parameter int RX_BUFFER_BYTES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [lfsx_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lfsx_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // byte input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] payload_byte, [17:8] payload_index, [25:18] frame_ctrl,
    // [33:26] frame_cmd, [43:34] frame_data_len, [44] prm_flag,
    // [45] exception_flag, [53:46] exc_code, [55:54] zero
    output logic [55:0] m_axis_tdata,
    // [2:0] status, [3] payload_valid
    output logic [3:0]  m_axis_tuser
);

    lfsx_pkg::t_cfg    r_cfg;
    lfsx_pkg::t_result res;
    lfsx_pkg::t_result r_res;
    logic              r_out_valid;
    logic              accept;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_head   <= lfsx_pkg::RST_FRAME_HEAD;
            r_cfg.max_data_len <= lfsx_pkg::RST_MAX_DATA;
            r_cfg.prm_mask     <= '0;
            r_cfg.respond_mask <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lfsx_pkg::REG_FRAME_HEAD:   r_cfg.frame_head   <= i_cfg_data[7:0];
                lfsx_pkg::REG_MAX_DATA_LEN: r_cfg.max_data_len <= i_cfg_data;
                lfsx_pkg::REG_PRM_MASK:     r_cfg.prm_mask     <= i_cfg_data[7:0];
                lfsx_pkg::REG_RESPOND_MASK: r_cfg.respond_mask <= i_cfg_data[7:0];
            endcase
        end
    end

    lfsx_parser #(
        .RX_BUFFER_BYTES (RX_BUFFER_BYTES)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (accept),
        .i_byte  (s_axis_tdata),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = {r_res.payload_valid, r_res.status};
    assign m_axis_tdata  = {2'b00,
                            r_res.exc_code,
                            r_res.exception_flag,
                            r_res.prm_flag,
                            r_res.frame_data_len,
                            r_res.frame_cmd,
                            r_res.frame_ctrl,
                            r_res.payload_index,
                            r_res.payload_byte};

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted byte left no result");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_out_valid && !m_axis_tready))
        else $error("input stalled without a pending result");

    a_ready_no_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_res.status != lfsx_pkg::ST_BUSY)) |-> !r_res.payload_valid)
        else $error("frame status together with a payload byte");

endmodule
